@@ src/pixel_strip_rotate_shift_top_macros.svh @@
// Assertion macros for the pixel strip rotate/shift block.
// Used by pixel_strip_rotate_shift_top; expects clk_i and rst_ni in scope.
`ifndef PIXEL_STRIP_ROTATE_SHIFT_TOP_MACROS_SVH
`define PIXEL_STRIP_ROTATE_SHIFT_TOP_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every rising clock edge out of reset
`define PXR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pxr assertion failed");

// cond must never be true out of reset
`define PXR_ASSERT_NEVER(lbl, cond) \
  `PXR_ASSERT(lbl, !(cond))

`else

`define PXR_ASSERT(lbl, prop)
`define PXR_ASSERT_NEVER(lbl, cond)

`endif

`endif

@@ src/pxr_pkg.sv @@
// Shared constants and controller/datapath interface types for the pixel strip block.
// No dependencies.
package pxr_pkg;

  localparam int MAX_PIXELS = 64;
  localparam int IDX_W      = $clog2(MAX_PIXELS);      // pixel address
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1);  // holds 0..MAX_PIXELS
  localparam int NP_W       = 7;                       // num_pixels register
  localparam int ACT_W      = 3;
  localparam int DIST_W     = 16;
  localparam int DBIT_W     = $clog2(DIST_W);
  localparam int COLOR_W    = 24;
  localparam int RAM_AW     = IDX_W + 1;               // bank bit + pixel address
  localparam int RAM_DEPTH  = 2 * MAX_PIXELS;
  localparam logic [NP_W-1:0] NP_RESET = NP_W'(64);

  localparam logic [ACT_W-1:0] ACT_WRITE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ROTL  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ROTR  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SHL   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_SHR   = 3'd5;

  typedef struct packed {
    logic load;       // latch the accepted item
    logic clr_step;   // write one zero entry of the clearing pass
    logic pix_write;  // single pixel write
    logic div_start;  // start distance mod n
    logic div_step;   // one restoring division step
    logic mv_start;   // set up the bank copy
    logic mv_step;    // one copy read / write
    logic out_load;   // load the result register
    logic flip;       // swap active bank
  } pxr_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_write;
    logic is_read;
    logic is_move;
    logic div_done;
    logic k_zero;
    logic mv_done;
    logic out_free;
  } pxr_status_t;

endpackage

@@ src/pxr_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pxr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/pxr_ctrl.sv @@
// Controller state machine for the pixel strip block.
// Depends on pxr_pkg.
module pxr_ctrl
  import pxr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  pxr_status_t status_i,
  output pxr_cmd_t    cmd_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DISP  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MVCHK = 3'd4;
  localparam logic [2:0] S_MOVE  = 3'd5;
  localparam logic [2:0] S_RDOUT = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        if (status_i.is_write) begin
          cmd_o.pix_write = 1'b1;
          state_d         = S_IDLE;
        end else if (status_i.is_read) begin
          state_d = S_RDOUT;
        end else if (status_i.is_move) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) state_d = S_MVCHK;
      end
      S_MVCHK: begin
        if (status_i.k_zero) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.mv_start = 1'b1;
          state_d        = S_MOVE;
        end
      end
      S_MOVE: begin
        cmd_o.mv_step = 1'b1;
        if (status_i.mv_done) begin
          cmd_o.flip = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_RDOUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/pxr_dpath.sv @@
// Datapath for the pixel strip block: item registers, divider, bank copy, RAM, result.
// Depends on pxr_pkg and pxr_ram.
module pxr_dpath
  import pxr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pxr_cmd_t           cmd_i,
  output pxr_status_t        status_o,
  input  logic [ACT_W-1:0]   action_i,
  input  logic [IDX_W-1:0]   pixel_index_i,
  input  logic [DIST_W-1:0]  distance_i,
  input  logic [COLOR_W-1:0] color_i,
  input  logic               cfg_valid_i,
  input  logic [NP_W-1:0]    cfg_num_pixels_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [COLOR_W-1:0] read_color_o
);

  localparam int EXT_W = (NP_W > CNT_W) ? NP_W : CNT_W;

  // configuration and pixels in use
  logic [NP_W-1:0]  np_q;
  logic [EXT_W-1:0] np_ext;
  logic [CNT_W-1:0] n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      np_q <= NP_RESET;
    end else if (cfg_valid_i) begin
      np_q <= cfg_num_pixels_i;
    end
  end

  assign np_ext = EXT_W'(np_q);

  always_comb begin
    if (np_q == '0) begin
      n = CNT_W'(1);
    end else if (np_ext > EXT_W'(MAX_PIXELS)) begin
      n = CNT_W'(MAX_PIXELS);
    end else begin
      n = CNT_W'(np_q);
    end
  end

  // latched item
  logic [ACT_W-1:0]   act_q;
  logic [IDX_W-1:0]   idx_q;
  logic [DIST_W-1:0]  dist_q;
  logic [COLOR_W-1:0] color_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q   <= action_i;
      idx_q   <= pixel_index_i;
      dist_q  <= distance_i;
      color_q <= color_i;
    end
  end

  logic in_range, is_left, is_shift;
  assign in_range = ({1'b0, idx_q} < n);
  assign is_left  = (act_q == ACT_ROTL) || (act_q == ACT_SHL);
  assign is_shift = (act_q == ACT_SHL) || (act_q == ACT_SHR);

  // restoring division: distance mod n, one dividend bit per step
  logic [DIST_W-1:0] dsh_q;
  logic [CNT_W-1:0]  rem_q;
  logic [DBIT_W-1:0] dbit_q;
  logic [CNT_W:0]    trial;
  logic [IDX_W-1:0]  k;

  assign trial = {rem_q, dsh_q[DIST_W-1]};
  assign k     = rem_q[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dsh_q  <= dist_q;
      rem_q  <= '0;
      dbit_q <= DBIT_W'(DIST_W - 1);
    end else if (cmd_i.div_step) begin
      dsh_q  <= {dsh_q[DIST_W-2:0], 1'b0};
      dbit_q <= dbit_q - 1'b1;
      if (trial >= {1'b0, n}) begin
        rem_q <= CNT_W'(trial - {1'b0, n});
      end else begin
        rem_q <= CNT_W'(trial);
      end
    end
  end

  // bank copy: read active bank, write the other, one entry a cycle
  logic             cur_q;
  logic [CNT_W-1:0] mi_q;
  logic [IDX_W-1:0] src_q;
  logic             wv_q, wlast_q, wfill_q;
  logic [IDX_W-1:0] widx_q;
  logic             rd_go, mi_in_use, fill_d;
  logic [CNT_W-1:0] src_inc;
  logic [CNT_W:0]   mi_plus_k;

  assign rd_go     = cmd_i.mv_step && (mi_q < CNT_W'(MAX_PIXELS));
  assign mi_in_use = (mi_q < n);
  assign src_inc   = CNT_W'(src_q) + 1'b1;
  assign mi_plus_k = {1'b0, mi_q} + (CNT_W + 1)'(k);

  always_comb begin
    if (is_left) begin
      fill_d = mi_plus_k >= {1'b0, n};
    end else begin
      fill_d = mi_q < CNT_W'(k);
    end
    fill_d = fill_d && is_shift && mi_in_use;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mv_start) begin
      mi_q <= '0;
      if (is_left) begin
        src_q <= k;
      end else begin
        src_q <= IDX_W'(n - CNT_W'(k));
      end
    end else if (rd_go) begin
      mi_q <= mi_q + 1'b1;
      if (mi_in_use) begin
        src_q <= (src_inc == n) ? '0 : src_inc[IDX_W-1:0];
      end
    end
    widx_q  <= mi_q[IDX_W-1:0];
    wlast_q <= (mi_q == CNT_W'(MAX_PIXELS - 1));
    wfill_q <= fill_d;
  end

  // clearing pass counter
  logic [IDX_W-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= 1'b0;
      wv_q  <= 1'b0;
      clr_q <= '0;
    end else begin
      wv_q <= rd_go;
      if (cmd_i.flip) cur_q <= ~cur_q;
      if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
    end
  end

  // RAM ports
  logic              we;
  logic [RAM_AW-1:0] waddr, raddr;
  logic [COLOR_W-1:0] wdata, rdata;

  always_comb begin
    we    = 1'b0;
    waddr = {cur_q, idx_q};
    wdata = color_q;
    if (cmd_i.clr_step) begin
      we    = 1'b1;
      waddr = {1'b0, clr_q};
      wdata = '0;
    end else if (cmd_i.pix_write) begin
      we = in_range;
    end else if (wv_q) begin
      we    = 1'b1;
      waddr = {~cur_q, widx_q};
      wdata = wfill_q ? color_q : rdata;
    end
  end

  always_comb begin
    if (cmd_i.mv_step) begin
      raddr = {cur_q, mi_in_use ? src_q : mi_q[IDX_W-1:0]};
    end else begin
      raddr = {cur_q, idx_q};
    end
  end

  pxr_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // result register
  logic               out_valid_q;
  logic [COLOR_W-1:0] read_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      read_color_q <= in_range ? rdata : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_color_o = read_color_q;

  always_comb begin
    status_o          = '0;
    status_o.clr_done = (clr_q == IDX_W'(MAX_PIXELS - 1));
    status_o.is_write = (act_q == ACT_WRITE);
    status_o.is_read  = (act_q == ACT_READ);
    status_o.is_move  = (act_q == ACT_ROTL) || (act_q == ACT_ROTR) ||
                        (act_q == ACT_SHL) || (act_q == ACT_SHR);
    status_o.div_done = (dbit_q == '0);
    status_o.k_zero   = (rem_q == '0);
    status_o.mv_done  = wv_q && wlast_q;
    status_o.out_free = !out_valid_q || !out_stall_i;
  end

endmodule

@@ src/pixel_strip_rotate_shift_top.sv @@
// One item at a time, the input stalled until it is done: a write, a read up to
// the result register, or a rotate/shift (16 divider steps, then one RAM copy per
// entry, with no copy when the distance reduces to zero). Writes and copies use
// the single write port of the pixel RAM. The result register frees the input side.
// Reset: asynchronous, active low; a clearing pass then zeroes the pixel store,
// with input stalled and configuration writes still taken.
module pixel_strip_rotate_shift_top
  import pxr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // input item channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ACT_W-1:0]   action_i,
  input  logic [IDX_W-1:0]   pixel_index_i,
  input  logic [DIST_W-1:0]  distance_i,
  input  logic [COLOR_W-1:0] color_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COLOR_W-1:0] read_color_o,
  // num_pixels write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [NP_W-1:0]    cfg_num_pixels_i
);

`include "pixel_strip_rotate_shift_top_macros.svh"

  pxr_cmd_t    cmd;
  pxr_status_t status;

  // Writes are taken at any time; the host is to write only while the block is idle, not enforced here.
  assign cfg_ready_o = 1'b1;

  // Sequencer: clear pass, dispatch, divide, bank copy, result transfer.
  pxr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Moves with a nonzero distance mod n copy every entry from the active RAM bank
  // to the other and swap banks; entries beyond the pixels in use copy unchanged.
  pxr_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .action_i         (action_i),
    .pixel_index_i    (pixel_index_i),
    .distance_i       (distance_i),
    .color_i          (color_i),
    .cfg_valid_i      (cfg_valid_i & cfg_ready_o),
    .cfg_num_pixels_i (cfg_num_pixels_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .read_color_o     (read_color_o)
  );

  // an accepted item always takes the controller out of idle
  `PXR_ASSERT(a_accept_busy, (in_valid_i && !in_stall_o) |=> in_stall_o)
  // a result is never loaded over one still waiting to transfer
  `PXR_ASSERT(a_load_free, cmd.out_load |-> status.out_free)
  // the divider stops after its last step
  `PXR_ASSERT(a_div_stop, (cmd.div_step && status.div_done) |=> !cmd.div_step)
  // bank copy and pixel write never compete for the write port
  `PXR_ASSERT_NEVER(a_wr_excl, cmd.pix_write && cmd.mv_step)

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for pixel_strip_rotate_shift_top: pixel write/read, rotate and shift.
// Depends on pxr_pkg and the block's RTL only; a scoreboard class predicts every read.
module testbench
  import pxr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes the block ignores
  localparam logic [ACT_W-1:0] ACT_IDLE6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_IDLE7 = 3'd7;

  // A move takes 16 divider steps plus one copy per entry; give it some slack
  localparam int SETTLE_CYCLES = 20 + MAX_PIXELS + 16;
  // Limit for the whole run; keep a wide margin over the slowest run
  localparam int CYCLE_LIMIT   = 600000;
  localparam int HOLD_OFF_LEN  = 300;

  // Predicts the pixel store and queues the colors that reads should return
  class strip_model;
    logic [COLOR_W-1:0] colors [MAX_PIXELS];
    logic [NP_W-1:0]    num_pixels;
    logic [COLOR_W-1:0] pending_reads [$];
    int                 errors;

    function new();
      foreach (colors[i]) colors[i] = '0;
      num_pixels = NP_RESET;
      errors     = 0;
    endfunction

    function int unsigned in_use();
      if (num_pixels == 0) return 1;
      if (num_pixels > MAX_PIXELS) return MAX_PIXELS;
      return num_pixels;
    endfunction

    // pixel i takes old pixel (i + k) mod n
    function void rotate_left(int unsigned n, int unsigned k);
      logic [COLOR_W-1:0] tmp [MAX_PIXELS];
      for (int unsigned i = 0; i < n; i++) tmp[i] = colors[(i + k) % n];
      for (int unsigned i = 0; i < n; i++) colors[i] = tmp[i];
    endfunction

    function void apply_command(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx,
                                logic [DIST_W-1:0] shift_amt, logic [COLOR_W-1:0] color);
      int unsigned n;
      int unsigned k;
      n = in_use();
      k = shift_amt % n;
      case (act)
        ACT_WRITE: begin
          if (idx < n) colors[idx] = color;
        end
        ACT_READ: begin
          pending_reads.push_back((idx < n) ? colors[idx] : '0);
        end
        ACT_ROTL, ACT_SHL: begin
          if (k != 0) begin
            rotate_left(n, k);
            if (act == ACT_SHL)
              for (int unsigned i = n - k; i < n; i++) colors[i] = color;
          end
        end
        ACT_ROTR, ACT_SHR: begin
          if (k != 0) begin
            rotate_left(n, n - k);
            if (act == ACT_SHR)
              for (int unsigned i = 0; i < k; i++) colors[i] = color;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_read(logic [COLOR_W-1:0] got);
      logic [COLOR_W-1:0] want;
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected read result, expected none, got %06h", $time, got);
        errors++;
        return;
      end
      want = pending_reads.pop_front();
      if (got !== want) begin
        $display("%0t: read_color mismatch, expected %06h, got %06h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_ni;
  logic               in_valid;
  logic               in_stall;
  logic [ACT_W-1:0]   action;
  logic [IDX_W-1:0]   pixel_index;
  logic [DIST_W-1:0]  distance;
  logic [COLOR_W-1:0] color;
  logic               out_valid;
  logic               out_stall;
  logic [COLOR_W-1:0] read_color;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [NP_W-1:0]    cfg_num_pixels;

  strip_model  model;
  int unsigned sender_max_gap;
  int unsigned receiver_max_stall;
  int unsigned hold_off_cycles;
  int unsigned cycle_count;

  pixel_strip_rotate_shift_top uut (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .action_i         (action),
    .pixel_index_i    (pixel_index),
    .distance_i       (distance),
    .color_i          (color),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .read_color_o     (read_color),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_num_pixels_i (cfg_num_pixels)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: a hung handshake or a lost read ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side. Stall is drawn per transfer and applied whether or not a
  // result is up, so it lands on every phase of the block's work. A long
  // hold-off requested by the main sequence replaces one draw.
  initial begin : result_sink
    int unsigned stall_len;
    out_stall = 1'b0;
    forever begin
      if (hold_off_cycles != 0) begin
        stall_len       = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall_len = $urandom_range(0, receiver_max_stall);
      end
      if (stall_len != 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      // stall is low from here on, so valid at an edge means a transfer
      do @(posedge clk); while (!out_valid);
      model.check_read(read_color);
    end
  end

  // One input transfer after a random gap; payload holds while stalled.
  // Called at a rising edge, returns at the edge of the transfer.
  task automatic send_command(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                              input logic [DIST_W-1:0] shift_amt,
                              input logic [COLOR_W-1:0] col);
    int unsigned gap;
    gap = $urandom_range(0, sender_max_gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    pixel_index <= idx;
    distance    <= shift_amt;
    color       <= col;
    do @(posedge clk); while (in_stall);
    model.apply_command(act, idx, shift_amt, col);
  endtask

  // Called with the block idle or, once, during the clearing pass; never twice in a row
  task automatic write_num_pixels(input logic [NP_W-1:0] value);
    cfg_valid      <= 1'b1;
    cfg_num_pixels <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid        <= 1'b0;
    model.num_pixels = value;
  endtask

  // Drain: every read answered, then room for a move still in flight
  task automatic settle();
    in_valid <= 1'b0;
    while (model.pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly indexes and distances that matter for the current strip length,
  // with full-range values mixed in. counted is low for items the block ignores.
  task automatic random_command(output bit counted);
    int unsigned        n;
    int unsigned        pick;
    int unsigned        sel;
    logic [ACT_W-1:0]   act;
    logic [IDX_W-1:0]   idx;
    logic [DIST_W-1:0]  shift_amt;
    logic [COLOR_W-1:0] col;
    n    = model.in_use();
    pick = $urandom_range(0, 99);
    if (pick < 30)      act = ACT_WRITE;
    else if (pick < 60) act = ACT_READ;
    else if (pick < 95) begin
      case (pick % 4)
        0:       act = ACT_ROTL;
        1:       act = ACT_ROTR;
        2:       act = ACT_SHL;
        default: act = ACT_SHR;
      endcase
    end else begin
      act = pick[0] ? ACT_IDLE6 : ACT_IDLE7;
    end

    if ($urandom_range(0, 3) != 0) idx = IDX_W'($urandom_range(0, n - 1));
    else                           idx = IDX_W'($urandom_range(0, MAX_PIXELS - 1));

    sel = $urandom_range(0, 9);
    if (sel < 4)      shift_amt = DIST_W'($urandom_range(0, 2 * n));
    else if (sel < 6) shift_amt = DIST_W'(n * $urandom_range(0, 65535 / n));
    else              shift_amt = DIST_W'($urandom);

    sel = $urandom_range(0, 7);
    if (sel == 0)      col = '0;
    else if (sel == 1) col = '1;
    else               col = COLOR_W'($urandom);

    counted = !(act == ACT_IDLE6 || act == ACT_IDLE7 || (act == ACT_WRITE && idx >= n));
    send_command(act, idx, shift_amt, col);
  endtask

  initial begin : main_sequence
    int unsigned     done;
    bit              counted;
    logic [NP_W-1:0] np_value;
    int unsigned     np_list [11];

    np_list = '{64, 1, 2, 63, 127, 0, 8, 65, 3, 64, 17};
    model              = new();
    cycle_count        = 0;
    hold_off_cycles    = 0;
    sender_max_gap     = 0;
    receiver_max_stall = 0;
    rst_ni             = 1'b0;
    in_valid           = 1'b0;
    action             = ACT_WRITE;
    pixel_index        = '0;
    distance           = '0;
    color              = '0;
    cfg_valid          = 1'b0;
    cfg_num_pixels     = NP_RESET;

    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;

    // Taken during the clearing pass; input stays stalled until it ends
    write_num_pixels(NP_RESET);

    // Directed: full strip, extremes of index/distance/color, every action
    send_command(ACT_WRITE, 0, 0, 24'hFFFFFF);
    send_command(ACT_WRITE, 63, 16'hFFFF, 24'h000001);
    send_command(ACT_WRITE, 1, 0, 24'h800000);
    send_command(ACT_ROTL, 0, 1, 24'h000000);
    send_command(ACT_READ, 63, 0, 24'h000000);
    send_command(ACT_ROTR, 0, 16'hFFFF, 24'h000000);   // 63 mod 64
    send_command(ACT_SHL, 0, 64, 24'h5A5A5A);          // whole turn: no move, no fill
    send_command(ACT_SHR, 0, 3, 24'hABCDEF);
    send_command(ACT_READ, 3, 0, 24'h000000);
    send_command(ACT_SHL, 0, 16'hFFFF, 24'h123456);
    send_command(ACT_READ, 0, 0, 24'h000000);
    send_command(ACT_IDLE6, 5, 1, 24'hFFFFFF);
    send_command(ACT_IDLE7, 5, 1, 24'hFFFFFF);
    send_command(ACT_ROTL, 63, 16'h8000, 24'hFFFFFF);  // 32768 mod 64 is zero
    send_command(ACT_READ, 1, 0, 24'h000000);
    settle();

    // Short strip: indexes past the end
    write_num_pixels(5);
    send_command(ACT_WRITE, 10, 0, 24'h0F0F0F);        // ignored
    send_command(ACT_WRITE, 4, 0, 24'h00FF00);
    send_command(ACT_READ, 10, 0, 24'h000000);         // out of range reads zero
    send_command(ACT_ROTR, 0, 7, 24'h000000);
    send_command(ACT_SHR, 0, 10, 24'h111111);          // multiple of n
    send_command(ACT_SHL, 0, 4, 24'h222222);
    send_command(ACT_READ, 0, 0, 24'h000000);
    settle();

    // Zero register means a single pixel
    write_num_pixels(0);
    send_command(ACT_SHL, 0, 3, 24'hFFFFFF);
    send_command(ACT_READ, 1, 0, 24'h000000);
    settle();

    // Random phases: each its own strip length and idling mode
    for (int p = 0; p < 11; p++) begin
      np_value = (p == 9) ? NP_W'($urandom_range(1, 127)) : NP_W'(np_list[p]);
      write_num_pixels(np_value);
      if (p % 3 == 2) begin
        sender_max_gap     = 0;
        receiver_max_stall = 0;
      end else begin
        sender_max_gap     = 12;
        receiver_max_stall = 12;
      end

      // Back-pressure: receiver holds off while reads keep coming, so the
      // result register fills and the input side stalls
      if (p == 4) begin
        sender_max_gap  = 0;
        hold_off_cycles = HOLD_OFF_LEN;
        for (int i = 0; i < 30; i++) begin
          if ($urandom_range(0, 3) == 0)
            send_command(ACT_WRITE, IDX_W'($urandom_range(0, MAX_PIXELS - 1)),
                         DIST_W'($urandom), COLOR_W'($urandom));
          else
            send_command(ACT_READ, IDX_W'($urandom_range(0, MAX_PIXELS - 1)),
                         DIST_W'($urandom), COLOR_W'($urandom));
        end
        sender_max_gap = 12;
      end

      done = 0;
      while (done < 42) begin
        random_command(counted);
        if (counted) done++;
      end
      // Sender pauses here until every read has come back
      settle();
    end

    if (model.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/pxr_pkg.sv
src/pxr_ram.sv
src/pxr_ctrl.sv
src/pxr_dpath.sv
src/pixel_strip_rotate_shift_top.sv
tb/testbench.sv
